@@ rtl/core/aes_pkg.sv @@
// Shared constants, types and byte functions for the AES-128 core.
package aes_pkg;

    localparam int RoundCount = 10;
    localparam int KeyCount   = RoundCount + 1;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    typedef logic [127:0] t_block;

    // one pipeline beat handed from cell to cell
    typedef struct packed {
        logic   valid;
        logic   decrypt;
        t_block data;
    } t_beat;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // GF(2^8) doubling
    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 at the top
    function automatic logic [7:0] blk_byte(input t_block b, input int i);
        blk_byte = b[127 - 8*i -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
    endfunction

endpackage

@@ rtl/core/aes128_block_cipher_core.sv @@
// Top level of the pipelined AES-128 ECB cipher core.
// Usage:
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 key_high,
//   1 key_low) and i_cfg_data. o_cfg_ready is high only while no block is
//   in flight. Each key beat loads one half of the key; the chain of key cells
//   then settles the round keys, and o_ready stays low until they have
//   settled. While i_cfg_valid is high, o_ready is low.
//   Input channel: i_valid/o_ready with i_operation (0 encrypt, 1 decrypt),
//   i_block_high and i_block_low. Output channel: o_valid/i_ready with
//   o_result_high and o_result_low.
//   Throughput: one block per cycle while o_ready is high. Input beat to
//   o_valid passes one input key add register, then ten round cells in a row.
//   The chain of round cells advances as a whole; when the receiver stalls
//   with a result waiting, the whole chain holds and o_ready drops.
//   Reset clears all valid flags and both key registers; the round keys of
//   the zero key then settle through the key cells, with o_ready low.
module aes128_block_cipher_core
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);
    logic   [63:0] r_key_high, r_key_low;
    t_block rkey [KeyCount];
    logic   [7:0] rcon [RoundCount];
    t_beat  beat [KeyCount];
    t_beat  r_in;
    logic   adv;
    logic   busy;
    logic   cfg_fire;
    logic   in_fire;
    logic   [3:0] r_settle;
    t_block n_in_data;

    // any beat in flight
    always_comb begin
        busy = 1'b0;
        for (int k = 0; k < KeyCount; k++) begin
            busy = busy | beat[k].valid;
        end
    end

    // whole chain moves unless the last beat is stuck
    assign adv         = !beat[RoundCount].valid || i_ready;
    assign o_ready     = adv && (r_settle == 4'd0) && !i_cfg_valid;
    assign o_cfg_ready = !busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_valid && o_ready;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cycles left until the key chain holds the new round keys
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 4'(RoundCount);
        end else if (cfg_fire) begin
            r_settle <= 4'(RoundCount);
        end else if (r_settle != 4'd0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    assign rkey[0] = {r_key_high, r_key_low};

    // key cells, each one round constant
    always_comb begin
        rcon[0] = 8'h01;
        for (int k = 1; k < RoundCount; k++) begin
            rcon[k] = xtime(rcon[k-1]);
        end
    end

    for (genvar k = 1; k < KeyCount; k++) begin : g_key
        aes_key_cell u_key (
            .i_clk      (i_clk),
            .i_load     (1'b1),
            .i_rcon     (rcon[k-1]),
            .i_prev_key (rkey[k-1]),
            .o_key      (rkey[k])
        );
    end

    // entry add of round key 0 (encrypt) or 10 (decrypt)
    assign n_in_data = {i_block_high, i_block_low} ^ (i_operation ? rkey[RoundCount] : rkey[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (adv) begin
            r_in.valid   <= in_fire;
            r_in.decrypt <= i_operation;
            r_in.data    <= n_in_data;
        end
    end

    assign beat[0] = r_in;

    for (genvar r = 1; r < KeyCount; r++) begin : g_round
        aes_round_cell u_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_last    (r == RoundCount),
            .i_enc_key (rkey[r]),
            .i_dec_key (rkey[RoundCount - r]),
            .i_beat    (beat[r-1]),
            .o_beat    (beat[r])
        );
    end

    assign o_valid       = beat[RoundCount].valid;
    assign o_result_high = beat[RoundCount].data[127:64];
    assign o_result_low  = beat[RoundCount].data[63:0];
endmodule

@@ rtl/core/aes_key_cell.sv @@
// Key schedule cell: derives the next round key from the previous one.
module aes_key_cell
    import aes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  logic [7:0] i_rcon,
    input  t_block i_prev_key,
    output t_block o_key
);
    logic [31:0] w0, w1, w2, w3, t;
    t_block n_key;
    t_block r_key;

    // one expansion step, four words
    always_comb begin
        t  = sub_word({i_prev_key[23:0], i_prev_key[31:24]}) ^ {i_rcon, 24'h0};
        w0 = i_prev_key[127:96] ^ t;
        w1 = i_prev_key[95:64] ^ w0;
        w2 = i_prev_key[63:32] ^ w1;
        w3 = i_prev_key[31:0] ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;
endmodule

@@ rtl/core/aes_round_cell.sv @@
// Round cell: one registered encrypt or decrypt round of the pipeline.
module aes_round_cell
    import aes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_last,
    input  t_block i_enc_key,
    input  t_block i_dec_key,
    input  t_beat  i_beat,
    output t_beat  o_beat
);
    logic [7:0] s [16];
    logic [7:0] sh [16];
    logic [7:0] sb [16];
    logic [7:0] mx [16];
    logic [7:0] ak [16];
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3, q0, q1, q2, q3, e0, e1, e2, e3;
    t_block enc_out, dec_out;
    t_beat  r_beat;
    t_beat  n_beat;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = blk_byte(i_beat.data, i);
        end
        // encrypt: sub, shift left, mix (unless last), add key
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sh[r + 4*c] = FWD_BOX[s[r + 4*((c + r) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
            d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
            mx[4*c]   = d0 ^ d1 ^ a1 ^ a2 ^ a3;
            mx[4*c+1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
            mx[4*c+2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
            mx[4*c+3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
        end
        for (int i = 0; i < 16; i++) begin
            enc_out[127 - 8*i -: 8] = (i_last ? sh[i] : mx[i]) ^ blk_byte(i_enc_key, i);
        end
        // decrypt: shift right, inverse sub, add key, inverse mix (unless last)
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sb[r + 4*((c + r) % 4)] = INV_BOX[s[r + 4*c]];
            end
        end
        for (int i = 0; i < 16; i++) begin
            ak[i] = sb[i] ^ blk_byte(i_dec_key, i);
        end
        for (int c = 0; c < 4; c++) begin
            a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
            // x*9 = x^8x, x*11 = 9^2x, x*13 = 9^4x, x*14 = 2x^4x^8x
            d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
            q0 = xtime(d0); q1 = xtime(d1); q2 = xtime(d2); q3 = xtime(d3);
            e0 = xtime(q0); e1 = xtime(q1); e2 = xtime(q2); e3 = xtime(q3);
            mx[4*c]   = (d0^q0^e0) ^ (a1^e1^d1) ^ (a2^e2^q2) ^ (a3^e3);
            mx[4*c+1] = (a0^e0) ^ (d1^q1^e1) ^ (a2^e2^d2) ^ (a3^e3^q3);
            mx[4*c+2] = (a0^e0^q0) ^ (a1^e1) ^ (d2^q2^e2) ^ (a3^e3^d3);
            mx[4*c+3] = (a0^e0^d0) ^ (a1^e1^q1) ^ (a2^e2) ^ (d3^q3^e3);
        end
        for (int i = 0; i < 16; i++) begin
            dec_out[127 - 8*i -: 8] = i_last ? ak[i] : mx[i];
        end
        n_beat.valid   = i_beat.valid;
        n_beat.decrypt = i_beat.decrypt;
        n_beat.data    = i_beat.decrypt ? dec_out : enc_out;
    end

    // reset clears the valid flag only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;
endmodule

@@ rtl/core/aes_checker.sv @@
// Port-level checker for the AES-128 core, bound to the top level.
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high) && $stable(o_result_low))
        else $error("result changed under stall");

    // key writes only with an empty pipeline
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_valid)
        else $error("key write allowed with a result in flight");

    // no block taken next to a key write
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> !o_ready)
        else $error("input ready during a key write");

    // a stall blocks input
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stuck");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind aes128_block_cipher_core aes_checker u_aes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_high (o_result_high),
    .o_result_low  (o_result_low)
);
